// ===== hdl/pit_pkg.sv =====
`timescale 1ns / 1ps

package pit_pkg;

    localparam int COORD_BITS   = 16;
    localparam int DIF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS    = 2 * DIF_BITS;
    localparam int MINOR_BITS   = PROD_BITS + 1;
    localparam int TERM_BITS    = DIF_BITS + MINOR_BITS;
    localparam int SUM_BITS     = TERM_BITS + 2;

    // register stages inside one determinant pipeline
    localparam int DET_STAGES   = 5;

    localparam int N_IN_FIELDS  = 12;
    localparam int IN_BITS      = ((N_IN_FIELDS * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = 8;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POINT_Z = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIF_BITS-1:0]   dif_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [MINOR_BITS-1:0] minor_t;
    typedef logic signed [TERM_BITS-1:0]  term_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vtx_t;

    // sign of the triple product; negation of the 4x4 determinant does not
    // change equality between signs
    typedef struct packed {
        logic neg;
        logic zero;
    } sgn_t;

endpackage

// ===== hdl/pit_det.sv =====
`timescale 1ns / 1ps

module pit_det
    import pit_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  vtx_t row0,
    input  vtx_t row1,
    input  vtx_t row2,
    input  vtx_t row3,
    output sgn_t sgn
);

    // stage 1: edge vectors
    dif_t u_reg [3];
    dif_t v_reg [3];
    dif_t w_reg [3];
    dif_t u_next [3];
    dif_t v_next [3];
    dif_t w_next [3];

    // stage 2: minor products
    prod_t pr_reg [6];
    prod_t pr_next [6];
    dif_t  u2_reg [3];

    // stage 3: 2x2 minors
    minor_t m_reg [3];
    minor_t m_next [3];
    dif_t   u3_reg [3];

    // stage 4: triple product terms
    term_t t_reg [3];
    term_t t_next [3];

    // stage 5: sign
    sgn_t sgn_reg;
    sgn_t sgn_next;
    sum_t sum;

    always_comb begin
        u_next[0] = dif_t'($signed(row1.x)) - dif_t'($signed(row0.x));
        u_next[1] = dif_t'($signed(row1.y)) - dif_t'($signed(row0.y));
        u_next[2] = dif_t'($signed(row1.z)) - dif_t'($signed(row0.z));
        v_next[0] = dif_t'($signed(row2.x)) - dif_t'($signed(row0.x));
        v_next[1] = dif_t'($signed(row2.y)) - dif_t'($signed(row0.y));
        v_next[2] = dif_t'($signed(row2.z)) - dif_t'($signed(row0.z));
        w_next[0] = dif_t'($signed(row3.x)) - dif_t'($signed(row0.x));
        w_next[1] = dif_t'($signed(row3.y)) - dif_t'($signed(row0.y));
        w_next[2] = dif_t'($signed(row3.z)) - dif_t'($signed(row0.z));
    end

    always_comb begin
        pr_next[0] = prod_t'(v_reg[1]) * prod_t'(w_reg[2]);
        pr_next[1] = prod_t'(v_reg[2]) * prod_t'(w_reg[1]);
        pr_next[2] = prod_t'(v_reg[0]) * prod_t'(w_reg[2]);
        pr_next[3] = prod_t'(v_reg[2]) * prod_t'(w_reg[0]);
        pr_next[4] = prod_t'(v_reg[0]) * prod_t'(w_reg[1]);
        pr_next[5] = prod_t'(v_reg[1]) * prod_t'(w_reg[0]);
    end

    always_comb begin
        m_next[0] = minor_t'(pr_reg[0]) - minor_t'(pr_reg[1]);
        m_next[1] = minor_t'(pr_reg[2]) - minor_t'(pr_reg[3]);
        m_next[2] = minor_t'(pr_reg[4]) - minor_t'(pr_reg[5]);
    end

    always_comb begin
        t_next[0] = term_t'(u3_reg[0]) * term_t'(m_reg[0]);
        t_next[1] = term_t'(u3_reg[1]) * term_t'(m_reg[1]);
        t_next[2] = term_t'(u3_reg[2]) * term_t'(m_reg[2]);
    end

    always_comb begin
        sum = sum_t'(t_reg[0]) - sum_t'(t_reg[1]) + sum_t'(t_reg[2]);
        sgn_next.neg  = sum[SUM_BITS-1];
        sgn_next.zero = (sum == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg   <= u_next;
            v_reg   <= v_next;
            w_reg   <= w_next;
            pr_reg  <= pr_next;
            u2_reg  <= u_reg;
            m_reg   <= m_next;
            u3_reg  <= u2_reg;
            t_reg   <= t_next;
            sgn_reg <= sgn_next;
        end
    end

    assign sgn = sgn_reg;

endmodule

// ===== hdl/point_in_tetrahedron_test_top.sv =====
`timescale 1ns / 1ps

// Point-in-tetrahedron test. Takes one tetrahedron (four vertices) per clock
// while the output is not stalled and returns inside_res and degenerate after
// the transaction passes five pipeline stages per determinant (edge vectors,
// minor products, minors, triple-product terms, sign) and the output register.
// Five such determinant pipelines run side by side, so the sustained rate is
// one tetrahedron per cycle. A stalled output (m_tready low with m_tvalid high)
// freezes the whole pipeline and drops s_tready in the same cycle. The query
// point lives in three registers on the cfg port, which never back-pressures;
// write it only while no transaction is in flight. Arithmetic is exact.
module point_in_tetrahedron_test_top
    import pit_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, d_x, d_y, d_z
    input  logic [IN_BITS-1:0]      s_tdata,

    output logic                    m_tvalid,
    input  logic                    m_tready,
    // inside_res, degenerate, zero padding
    output logic [OUT_BITS-1:0]     m_tdata,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]   cfg_data
);

    coord_t point_x_reg;
    coord_t point_y_reg;
    coord_t point_z_reg;

    logic [DET_STAGES-1:0] vld_reg;
    logic                  m_tvalid_reg;
    logic                  inside_res_reg;
    logic                  degenerate_reg;
    logic                  en;

    vtx_t vtx_a;
    vtx_t vtx_b;
    vtx_t vtx_c;
    vtx_t vtx_d;
    vtx_t vtx_p;
    sgn_t sgn [5];

    assign en        = m_tready | ~m_tvalid_reg;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
            point_z_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_POINT_X: point_x_reg <= cfg_data;
                REG_POINT_Y: point_y_reg <= cfg_data;
                REG_POINT_Z: point_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign vtx_a = '{x: s_tdata[0*COORD_BITS +: COORD_BITS],
                     y: s_tdata[1*COORD_BITS +: COORD_BITS],
                     z: s_tdata[2*COORD_BITS +: COORD_BITS]};
    assign vtx_b = '{x: s_tdata[3*COORD_BITS +: COORD_BITS],
                     y: s_tdata[4*COORD_BITS +: COORD_BITS],
                     z: s_tdata[5*COORD_BITS +: COORD_BITS]};
    assign vtx_c = '{x: s_tdata[6*COORD_BITS +: COORD_BITS],
                     y: s_tdata[7*COORD_BITS +: COORD_BITS],
                     z: s_tdata[8*COORD_BITS +: COORD_BITS]};
    assign vtx_d = '{x: s_tdata[9*COORD_BITS +: COORD_BITS],
                     y: s_tdata[10*COORD_BITS +: COORD_BITS],
                     z: s_tdata[11*COORD_BITS +: COORD_BITS]};
    assign vtx_p = '{x: point_x_reg, y: point_y_reg, z: point_z_reg};

    pit_det u_det0 (.aclk(aclk), .en(en), .row0(vtx_a), .row1(vtx_b),
                    .row2(vtx_c), .row3(vtx_d), .sgn(sgn[0]));
    pit_det u_det1 (.aclk(aclk), .en(en), .row0(vtx_p), .row1(vtx_b),
                    .row2(vtx_c), .row3(vtx_d), .sgn(sgn[1]));
    pit_det u_det2 (.aclk(aclk), .en(en), .row0(vtx_a), .row1(vtx_p),
                    .row2(vtx_c), .row3(vtx_d), .sgn(sgn[2]));
    pit_det u_det3 (.aclk(aclk), .en(en), .row0(vtx_a), .row1(vtx_b),
                    .row2(vtx_p), .row3(vtx_d), .sgn(sgn[3]));
    pit_det u_det4 (.aclk(aclk), .en(en), .row0(vtx_a), .row1(vtx_b),
                    .row2(vtx_c), .row3(vtx_p), .sgn(sgn[4]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[DET_STAGES-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[DET_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en && vld_reg[DET_STAGES-1]) begin
            inside_res_reg <= (sgn[1] == sgn[2]) && (sgn[1] == sgn[3])
                              && (sgn[1] == sgn[4]);
            degenerate_reg <= sgn[0].zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_BITS-2){1'b0}}, degenerate_reg, inside_res_reg};

`ifndef ASSERT_OFF
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg) && $stable(m_tvalid_reg) && $stable(m_tdata))
        else $error("pipeline moved while output stalled");

    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        en && vld_reg[DET_STAGES-1] |=> m_tvalid)
        else $error("item lost at output stage");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && (vld_reg == '0))
        else $error("pipeline not empty after reset");
`endif

endmodule
